// ----- rtl/dtd_pkg.sv -----
// ----------------------------------------------------------------------------
// dtd_pkg
// Shared types, constants and tables of the decimal text to double parser.
// ----------------------------------------------------------------------------
package dtd_pkg;

  typedef enum logic [0:0] {
    FPU_MUL,
    FPU_ADD
  } fpu_op_t;

  // operand pairs fed to the float unit
  typedef enum logic [1:0] {
    SEL_RV_TEN,
    SEL_RES_DIGIT,
    SEL_NUM_P10,
    SEL_P10_P10
  } fpu_sel_t;

  typedef struct packed {
    logic     cap;
    logic     fpu_go;
    fpu_op_t  fpu_op;
    fpu_sel_t fpu_sel;
    logic     wr_rv;
    logic     wr_num;
    logic     wr_p10;
    logic     set_mneg;
    logic     set_eneg;
    logic     inc_frac;
    logic     exp_digit;
    logic     scale_init;
    logic     n_shift;
    logic     emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_digit;
    logic is_dot;
    logic is_plus;
    logic is_minus;
    logic is_exp;
    logic last;
    logic fpu_done;
    logic n_zero;
    logic n_odd;
  } dp_status_t;

  localparam logic [63:0] DBL_TEN         = 64'h4024_0000_0000_0000;
  localparam logic [63:0] DBL_TENTH       = 64'h3FB9_9999_9999_999A;
  localparam logic [63:0] DBL_DEFAULT_NAN = 64'hFFF8_0000_0000_0000;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_LE    = 8'h65;
  localparam logic [7:0] CH_UE    = 8'h45;

  function automatic logic [63:0] digit_to_double(input logic [3:0] d);
    logic [63:0] r;
    case (d)
      4'd1:    r = 64'h3FF0_0000_0000_0000;
      4'd2:    r = 64'h4000_0000_0000_0000;
      4'd3:    r = 64'h4008_0000_0000_0000;
      4'd4:    r = 64'h4010_0000_0000_0000;
      4'd5:    r = 64'h4014_0000_0000_0000;
      4'd6:    r = 64'h4018_0000_0000_0000;
      4'd7:    r = 64'h401C_0000_0000_0000;
      4'd8:    r = 64'h4020_0000_0000_0000;
      4'd9:    r = 64'h4022_0000_0000_0000;
      default: r = 64'h0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/dtd_if.sv -----
// ----------------------------------------------------------------------------
// dtd_if
// Valid/ready channel interfaces for characters in and doubles out.
// ----------------------------------------------------------------------------
interface dtd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface

interface dtd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value_bits;

  modport source (output valid, output value_bits, input ready);
  modport sink (input valid, input value_bits, output ready);
endinterface

// ----- rtl/dtd_fpu.sv -----
// ----------------------------------------------------------------------------
// dtd_fpu
// Multi-cycle double multiply (full IEEE, round to nearest even) and add of
// two non-negative doubles, with a shared round and pack back end.
// ----------------------------------------------------------------------------
module dtd_fpu (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  dtd_pkg::fpu_op_t op,
  input  logic [63:0]      a,
  input  logic [63:0]      b,
  output logic             done,
  output logic [63:0]      result
);

  typedef enum logic [2:0] {
    F_IDLE, F_NORM, F_MULT, F_PNORM, F_ALIGN, F_SUM, F_RND1, F_RND2
  } fstate_t;

  fstate_t            state_r, state_nxt;
  logic               done_r, done_nxt;
  logic               sgn_r, sgn_nxt;
  logic signed [12:0] ea_r, ea_nxt, eb_r, eb_nxt, e_r, e_nxt;
  logic [52:0]        ma_r, ma_nxt, mb_r, mb_nxt, m_r, m_nxt;
  logic [106:0]       acc_r, acc_nxt;
  logic [53:0]        pp_r, pp_nxt;
  logic [2:0]         cnt_r, cnt_nxt;
  logic [105:0]       n_r, n_nxt;
  logic               stk_r, stk_nxt, g_r, g_nxt, s_r, s_nxt, ovf_r, ovf_nxt;
  logic [10:0]        efm1_r, efm1_nxt;
  logic [63:0]        res_r, res_nxt;

  // operand decode
  logic [10:0] fa, fb;
  logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
  assign fa     = a[62:52];
  assign fb     = b[62:52];
  assign nan_a  = (fa == 11'h7FF) && (a[51:0] != 52'd0);
  assign nan_b  = (fb == 11'h7FF) && (b[51:0] != 52'd0);
  assign inf_a  = (fa == 11'h7FF) && (a[51:0] == 52'd0);
  assign inf_b  = (fb == 11'h7FF) && (b[51:0] == 52'd0);
  assign zero_a = a[62:0] == 63'd0;
  assign zero_b = b[62:0] == 63'd0;

  logic signed [12:0] ea_in, eb_in;
  assign ea_in = (fa == 11'd0) ? 13'sd1 : signed'({2'b00, fa});
  assign eb_in = (fb == 11'd0) ? 13'sd1 : signed'({2'b00, fb});

  always_comb begin
    logic [26:0]        opx, opy;
    logic [106:0]       ppx;
    logic [213:0]       awide;
    logic [106:0]       sum;
    logic [12:0]        diff;
    logic [6:0]         dsh;
    logic signed [12:0] es, shn;
    logic [6:0]         rsh;
    logic [211:0]       rext;
    logic               inc;
    logic [62:0]        word;

    state_nxt = state_r;
    done_nxt  = 1'b0;
    sgn_nxt   = sgn_r;
    ea_nxt    = ea_r;
    eb_nxt    = eb_r;
    ma_nxt    = ma_r;
    mb_nxt    = mb_r;
    acc_nxt   = acc_r;
    pp_nxt    = pp_r;
    cnt_nxt   = cnt_r;
    e_nxt     = e_r;
    n_nxt     = n_r;
    stk_nxt   = stk_r;
    m_nxt     = m_r;
    g_nxt     = g_r;
    s_nxt     = s_r;
    efm1_nxt  = efm1_r;
    ovf_nxt   = ovf_r;
    res_nxt   = res_r;
    opx       = 27'd0;
    opy       = 27'd0;
    ppx       = 107'd0;
    awide     = 214'd0;
    sum       = 107'd0;
    diff      = 13'd0;
    dsh       = 7'd0;
    es        = 13'sd0;
    shn       = 13'sd0;
    rsh       = 7'd0;
    rext      = 212'd0;
    inc       = 1'b0;
    word      = 63'd0;

    case (state_r)
      F_IDLE: begin
        if (start) begin
          if (op == dtd_pkg::FPU_MUL) begin
            sgn_nxt = a[63] ^ b[63];
            if (nan_a) begin
              res_nxt  = {a[63], 11'h7FF, 1'b1, a[50:0]};
              done_nxt = 1'b1;
            end else if (nan_b) begin
              res_nxt  = {b[63], 11'h7FF, 1'b1, b[50:0]};
              done_nxt = 1'b1;
            end else if ((inf_a && zero_b) || (zero_a && inf_b)) begin
              res_nxt  = dtd_pkg::DBL_DEFAULT_NAN;
              done_nxt = 1'b1;
            end else if (inf_a || inf_b) begin
              res_nxt  = {a[63] ^ b[63], 11'h7FF, 52'd0};
              done_nxt = 1'b1;
            end else if (zero_a || zero_b) begin
              res_nxt  = {a[63] ^ b[63], 63'd0};
              done_nxt = 1'b1;
            end else begin
              ma_nxt    = {fa != 11'd0, a[51:0]};
              mb_nxt    = {fb != 11'd0, b[51:0]};
              ea_nxt    = ea_in;
              eb_nxt    = eb_in;
              state_nxt = F_NORM;
            end
          end else begin
            // both operands are non-negative here
            sgn_nxt = 1'b0;
            if (fa == 11'h7FF || zero_b) begin
              res_nxt  = a;
              done_nxt = 1'b1;
            end else if (zero_a) begin
              res_nxt  = b;
              done_nxt = 1'b1;
            end else begin
              if (eb_in > ea_in) begin
                ma_nxt = {fb != 11'd0, b[51:0]};
                mb_nxt = {fa != 11'd0, a[51:0]};
                ea_nxt = eb_in;
                eb_nxt = ea_in;
              end else begin
                ma_nxt = {fa != 11'd0, a[51:0]};
                mb_nxt = {fb != 11'd0, b[51:0]};
                ea_nxt = ea_in;
                eb_nxt = eb_in;
              end
              state_nxt = F_ALIGN;
            end
          end
        end
      end

      F_NORM: begin
        // subnormal operands: one bit of normalization per cycle
        if (ma_r[52] && mb_r[52]) begin
          acc_nxt   = 107'd0;
          cnt_nxt   = 3'd0;
          state_nxt = F_MULT;
        end else begin
          if (!ma_r[52]) begin
            ma_nxt = {ma_r[51:0], 1'b0};
            ea_nxt = ea_r - 13'sd1;
          end
          if (!mb_r[52]) begin
            mb_nxt = {mb_r[51:0], 1'b0};
            eb_nxt = eb_r - 13'sd1;
          end
        end
      end

      F_MULT: begin
        // four 27x27 partial products, product registered before accumulate
        case (cnt_r)
          3'd0: begin
            opx = ma_r[26:0];
            opy = mb_r[26:0];
          end
          3'd1: begin
            opx = ma_r[26:0];
            opy = {1'b0, mb_r[52:27]};
          end
          3'd2: begin
            opx = {1'b0, ma_r[52:27]};
            opy = mb_r[26:0];
          end
          default: begin
            opx = {1'b0, ma_r[52:27]};
            opy = {1'b0, mb_r[52:27]};
          end
        endcase
        pp_nxt = opx * opy;
        case (cnt_r)
          3'd1:    ppx = {53'd0, pp_r};
          3'd2:    ppx = {26'd0, pp_r, 27'd0};
          3'd3:    ppx = {26'd0, pp_r, 27'd0};
          3'd4:    ppx = {pp_r[52:0], 54'd0};
          default: ppx = 107'd0;
        endcase
        acc_nxt = acc_r + ppx;
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd4) begin
          state_nxt = F_PNORM;
        end
      end

      F_PNORM: begin
        es      = ea_r + eb_r;
        stk_nxt = 1'b0;
        if (acc_r[105]) begin
          n_nxt = acc_r[105:0];
          e_nxt = es - 13'sd1022;
        end else begin
          n_nxt = {acc_r[104:0], 1'b0};
          e_nxt = es - 13'sd1023;
        end
        state_nxt = F_RND1;
      end

      F_ALIGN: begin
        diff     = ea_r - eb_r;
        dsh      = (diff > 13'd107) ? 7'd107 : diff[6:0];
        awide    = {1'b0, mb_r, 53'd0, 107'd0} >> dsh;
        acc_nxt  = awide[213:107];
        stk_nxt  = |awide[106:0];
        state_nxt = F_SUM;
      end

      F_SUM: begin
        sum = {1'b0, ma_r, 53'd0} + acc_r;
        if (sum[106]) begin
          n_nxt   = sum[106:1];
          stk_nxt = stk_r | sum[0];
          e_nxt   = ea_r + 13'sd1;
        end else begin
          n_nxt = sum[105:0];
          e_nxt = ea_r;
        end
        state_nxt = F_RND1;
      end

      F_RND1: begin
        if (e_r > 13'sd0) begin
          m_nxt    = n_r[105:53];
          g_nxt    = n_r[52];
          s_nxt    = (|n_r[51:0]) | stk_r;
          efm1_nxt = e_r[10:0] - 11'd1;
          ovf_nxt  = e_r > 13'sd2046;
        end else begin
          // result is subnormal: shift right with sticky
          shn      = 13'sd1 - e_r;
          rsh      = (shn > 13'sd106) ? 7'd106 : shn[6:0];
          rext     = {n_r, 106'd0} >> rsh;
          m_nxt    = rext[211:159];
          g_nxt    = rext[158];
          s_nxt    = (|rext[157:0]) | stk_r;
          efm1_nxt = 11'd0;
          ovf_nxt  = 1'b0;
        end
        state_nxt = F_RND2;
      end

      F_RND2: begin
        inc  = g_r & (s_r | m_r[0]);
        word = {efm1_r, 52'd0} + {10'd0, m_r} + {62'd0, inc};
        res_nxt   = ovf_r ? {sgn_r, 11'h7FF, 52'd0} : {sgn_r, word};
        done_nxt  = 1'b1;
        state_nxt = F_IDLE;
      end

      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    sgn_r  <= sgn_nxt;
    ea_r   <= ea_nxt;
    eb_r   <= eb_nxt;
    ma_r   <= ma_nxt;
    mb_r   <= mb_nxt;
    acc_r  <= acc_nxt;
    pp_r   <= pp_nxt;
    cnt_r  <= cnt_nxt;
    e_r    <= e_nxt;
    n_r    <= n_nxt;
    stk_r  <= stk_nxt;
    m_r    <= m_nxt;
    g_r    <= g_nxt;
    s_r    <= s_nxt;
    efm1_r <= efm1_nxt;
    ovf_r  <= ovf_nxt;
    res_r  <= res_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == F_IDLE) else $error("fpu started while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> state_r == F_IDLE) else $error("fpu done while busy");
  a_mult_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == F_MULT && cnt_r == 3'd4) |=> state_r == F_PNORM)
    else $error("multiply sequence overran");

endmodule

// ----- rtl/dtd_datapath.sv -----
// ----------------------------------------------------------------------------
// dtd_datapath
// Character capture, running value, counters, scaling registers, float unit
// and result register.
// ----------------------------------------------------------------------------
module dtd_datapath #(
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [7:0]            in_char,
  input  logic                  in_last,
  input  dtd_pkg::ctrl_cmd_t    cmd,
  output dtd_pkg::dp_status_t   status,
  output logic [63:0]           out_bits
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic [7:0]            char_r;
  logic                  last_r;
  logic [63:0]           rv_r, rv_nxt, num_r, num_nxt, p10_r, p10_nxt;
  logic [COUNT_BITS-1:0] frac_r, frac_nxt, emag_r, emag_nxt;
  logic                  mneg_r, mneg_nxt, eneg_r, eneg_nxt;
  logic [COUNT_BITS:0]   n_r, n_nxt;
  logic [63:0]           out_r;

  logic        fpu_done;
  logic [63:0] fpu_res, fpu_a, fpu_b;

  always_comb begin
    case (cmd.fpu_sel)
      dtd_pkg::SEL_RV_TEN: begin
        fpu_a = rv_r;
        fpu_b = dtd_pkg::DBL_TEN;
      end
      dtd_pkg::SEL_RES_DIGIT: begin
        fpu_a = fpu_res;
        fpu_b = dtd_pkg::digit_to_double(char_r[3:0]);
      end
      dtd_pkg::SEL_NUM_P10: begin
        fpu_a = num_r;
        fpu_b = p10_r;
      end
      default: begin
        fpu_a = p10_r;
        fpu_b = p10_r;
      end
    endcase
  end

  dtd_fpu u_fpu (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.fpu_go),
    .op     (cmd.fpu_op),
    .a      (fpu_a),
    .b      (fpu_b),
    .done   (fpu_done),
    .result (fpu_res)
  );

  always_comb begin
    logic [COUNT_BITS+3:0]   mag10;
    logic signed [COUNT_BITS+1:0] es, ee;
    logic [COUNT_BITS+1:0]   ae;

    rv_nxt   = rv_r;
    num_nxt  = num_r;
    p10_nxt  = p10_r;
    frac_nxt = frac_r;
    emag_nxt = emag_r;
    mneg_nxt = mneg_r;
    eneg_nxt = eneg_r;
    n_nxt    = n_r;

    mag10 = ({4'd0, emag_r} << 3) + ({4'd0, emag_r} << 1)
            + {{COUNT_BITS{1'b0}}, char_r[3:0]};
    es    = eneg_r ? -signed'({2'b00, emag_r}) : signed'({2'b00, emag_r});
    ee    = es - signed'({2'b00, frac_r});
    ae    = ee[COUNT_BITS+1] ? -ee : ee;

    if (cmd.wr_rv)    rv_nxt  = fpu_res;
    if (cmd.wr_num)   num_nxt = fpu_res;
    if (cmd.wr_p10)   p10_nxt = fpu_res;
    if (cmd.set_mneg) mneg_nxt = 1'b1;
    if (cmd.set_eneg) eneg_nxt = 1'b1;
    if (cmd.inc_frac && frac_r != CNT_MAX) begin
      frac_nxt = frac_r + 1'b1;
    end
    if (cmd.exp_digit) begin
      emag_nxt = (mag10 > {4'd0, CNT_MAX}) ? CNT_MAX : mag10[COUNT_BITS-1:0];
    end
    if (cmd.scale_init) begin
      num_nxt = {mneg_r ^ rv_r[63], rv_r[62:0]};
      n_nxt   = ae[COUNT_BITS:0];
      p10_nxt = (ee > 0) ? dtd_pkg::DBL_TEN : dtd_pkg::DBL_TENTH;
    end
    if (cmd.n_shift) n_nxt = n_r >> 1;
    if (cmd.emit) begin
      rv_nxt   = 64'd0;
      frac_nxt = '0;
      emag_nxt = '0;
      mneg_nxt = 1'b0;
      eneg_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r   <= 64'd0;
      frac_r <= '0;
      emag_r <= '0;
      mneg_r <= 1'b0;
      eneg_r <= 1'b0;
    end else begin
      rv_r   <= rv_nxt;
      frac_r <= frac_nxt;
      emag_r <= emag_nxt;
      mneg_r <= mneg_nxt;
      eneg_r <= eneg_nxt;
    end
    num_r <= num_nxt;
    p10_r <= p10_nxt;
    n_r   <= n_nxt;
    if (cmd.cap) begin
      char_r <= in_char;
      last_r <= in_last;
    end
    if (cmd.emit) out_r <= num_r;
  end

  assign status.is_digit = (char_r >= dtd_pkg::CH_0) && (char_r <= dtd_pkg::CH_9);
  assign status.is_dot   = char_r == dtd_pkg::CH_DOT;
  assign status.is_plus  = char_r == dtd_pkg::CH_PLUS;
  assign status.is_minus = char_r == dtd_pkg::CH_MINUS;
  assign status.is_exp   = (char_r == dtd_pkg::CH_LE) || (char_r == dtd_pkg::CH_UE);
  assign status.last     = last_r;
  assign status.fpu_done = fpu_done;
  assign status.n_zero   = n_r == '0;
  assign status.n_odd    = n_r[0];
  assign out_bits        = out_r;

  a_frac_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (frac_r == CNT_MAX && cmd.inc_frac && !cmd.emit) |=> frac_r == CNT_MAX)
    else $error("fraction count wrapped");
  a_emag_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (emag_r == CNT_MAX && cmd.exp_digit && !cmd.emit) |=> emag_r == CNT_MAX)
    else $error("exponent magnitude dropped from saturation");
  a_emit_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (rv_r == 64'd0 && !mneg_r && !eneg_r))
    else $error("token state not cleared after result");

endmodule

// ----- rtl/dtd_ctrl.sv -----
// ----------------------------------------------------------------------------
// dtd_ctrl
// Parse phase machine and sequencer for digit updates and final scaling.
// ----------------------------------------------------------------------------
module dtd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  dtd_pkg::dp_status_t status,
  output dtd_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_CLASS, S_W_MUL10, S_W_ADD, S_INIT, S_SCALE, S_W_NUM, S_SQ,
    S_W_SQ, S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    PH_START, PH_INT, PH_FRAC, PH_ESIGN, PH_EDIG, PH_DEAD
  } phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    logic digit_step;

    state_nxt  = state_r;
    phase_nxt  = phase_r;
    cmd        = '0;
    cmd.fpu_op = dtd_pkg::FPU_MUL;
    cmd.fpu_sel = dtd_pkg::SEL_RV_TEN;
    digit_step = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_CLASS;
        end
      end

      S_CLASS: begin
        case (phase_r)
          PH_START: begin
            if (status.is_minus) begin
              cmd.set_mneg = 1'b1;
              phase_nxt    = PH_INT;
            end else if (status.is_plus) begin
              phase_nxt = PH_INT;
            end else if (status.is_digit) begin
              digit_step = 1'b1;
              phase_nxt  = PH_INT;
            end else if (status.is_dot) begin
              phase_nxt = PH_FRAC;
            end else if (status.is_exp) begin
              phase_nxt = PH_ESIGN;
            end else begin
              phase_nxt = PH_DEAD;
            end
          end
          PH_INT: begin
            if (status.is_digit) digit_step = 1'b1;
            else if (status.is_dot) phase_nxt = PH_FRAC;
            else if (status.is_exp) phase_nxt = PH_ESIGN;
            else phase_nxt = PH_DEAD;
          end
          PH_FRAC: begin
            if (status.is_digit) begin
              digit_step   = 1'b1;
              cmd.inc_frac = 1'b1;
            end else if (status.is_exp) begin
              phase_nxt = PH_ESIGN;
            end else begin
              phase_nxt = PH_DEAD;
            end
          end
          PH_ESIGN: begin
            if (status.is_minus) begin
              cmd.set_eneg = 1'b1;
              phase_nxt    = PH_EDIG;
            end else if (status.is_plus) begin
              phase_nxt = PH_EDIG;
            end else if (status.is_digit) begin
              cmd.exp_digit = 1'b1;
              phase_nxt     = PH_EDIG;
            end else begin
              phase_nxt = PH_DEAD;
            end
          end
          PH_EDIG: begin
            if (status.is_digit) cmd.exp_digit = 1'b1;
            else phase_nxt = PH_DEAD;
          end
          default: phase_nxt = PH_DEAD;
        endcase
        if (digit_step) begin
          cmd.fpu_go  = 1'b1;
          cmd.fpu_op  = dtd_pkg::FPU_MUL;
          cmd.fpu_sel = dtd_pkg::SEL_RV_TEN;
          state_nxt   = S_W_MUL10;
        end else begin
          state_nxt = status.last ? S_INIT : S_IDLE;
        end
      end

      S_W_MUL10: begin
        if (status.fpu_done) begin
          cmd.fpu_go  = 1'b1;
          cmd.fpu_op  = dtd_pkg::FPU_ADD;
          cmd.fpu_sel = dtd_pkg::SEL_RES_DIGIT;
          state_nxt   = S_W_ADD;
        end
      end

      S_W_ADD: begin
        if (status.fpu_done) begin
          cmd.wr_rv = 1'b1;
          state_nxt = status.last ? S_INIT : S_IDLE;
        end
      end

      S_INIT: begin
        cmd.scale_init = 1'b1;
        state_nxt      = S_SCALE;
      end

      S_SCALE: begin
        if (status.n_zero) begin
          state_nxt = S_EMIT;
        end else if (status.n_odd) begin
          cmd.fpu_go  = 1'b1;
          cmd.fpu_sel = dtd_pkg::SEL_NUM_P10;
          state_nxt   = S_W_NUM;
        end else begin
          cmd.n_shift = 1'b1;
          state_nxt   = S_SQ;
        end
      end

      S_W_NUM: begin
        if (status.fpu_done) begin
          cmd.wr_num  = 1'b1;
          cmd.n_shift = 1'b1;
          state_nxt   = S_SQ;
        end
      end

      S_SQ: begin
        // the last squaring is never used, so skip it
        if (status.n_zero) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.fpu_go  = 1'b1;
          cmd.fpu_sel = dtd_pkg::SEL_P10_P10;
          state_nxt   = S_W_SQ;
        end
      end

      S_W_SQ: begin
        if (status.fpu_done) begin
          cmd.wr_p10 = 1'b1;
          state_nxt  = S_SCALE;
        end
      end

      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit  = 1'b1;
          phase_nxt = PH_START;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (cmd.emit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_START;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.emit && out_valid_r && !out_ready)) else $error("result overwritten");
  a_wait_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_W_MUL10 || state_r == S_W_ADD || state_r == S_W_NUM ||
      state_r == S_W_SQ) && !status.fpu_done) |=> $stable(state_r))
    else $error("left wait state before float unit finished");
  a_dead_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DEAD && !cmd.emit) |=> phase_r == PH_DEAD)
    else $error("dead phase left before end of token");

endmodule

// ----- rtl/decimal_text_to_double_parser_unit.sv -----
// ----------------------------------------------------------------------------
// decimal_text_to_double_parser_unit
// Parses a decimal number token, one character per transfer, into an IEEE
// double.
//
//   channel  | dir | payload               | transfer when
//   in_ch    | in  | char_code, last_char  | valid && ready
//   out_ch   | out | value_bits            | valid && ready, one per token
//
// A mantissa digit takes one double multiply then one add on the shared
// float unit; zero operands finish straight from the float unit's idle state.
// After the last character, scaling takes up to COUNT_BITS+1 steps of one or
// two multiplies each. Subnormal operands add one normalize shift per leading
// zero in the multiplier's normalize step.
// Reset is synchronous, active low; no clearing pass. A result waits in an
// output register while the next token streams in; only a second finished
// result stalls on out_ch.ready.
// ----------------------------------------------------------------------------
module decimal_text_to_double_parser_unit #(
  parameter int COUNT_BITS = 16
) (
  input logic          clk,
  input logic          rst_n,
  dtd_in_if.sink       in_ch,
  dtd_out_if.source    out_ch
);

  dtd_pkg::ctrl_cmd_t  cmd;
  dtd_pkg::dp_status_t status;

  dtd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  dtd_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_char  (in_ch.char_code),
    .in_last  (in_ch.last_char),
    .cmd      (cmd),
    .status   (status),
    .out_bits (out_ch.value_bits)
  );

endmodule
